FILE: hw/rtl/mapu_pkg.sv
// Shared constants, register codes and controller/datapath types for the
// mass-action propensity unit. No dependencies.
`default_nettype none

package mapu_pkg;

  // Field and datapath widths.
  localparam int unsigned ORDER_W    = 3;
  localparam int unsigned MOLECULE_W = 32;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned HALF_W     = DATA_W / 2;
  localparam int unsigned MID_W      = HALF_W + 2;

  // Bits of the molecule count that take part in the falling factorial.
  localparam int unsigned COUNT_BITS = 32;

  // Highest stoichiometric order; larger codes are clamped to it.
  localparam logic [ORDER_W-1:0] MAX_ORDER = ORDER_W'(4);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = DATA_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_CONSTANT   = 1'b0,
    REG_REACTION_ACTIVE = 1'b1
  } cfg_reg_e;

  // Which 32x32 partial product the shared multiplier forms.
  typedef enum logic [1:0] {
    PH_LL = 2'd0,
    PH_LH = 2'd1,
    PH_HL = 2'd2
  } mul_phase_e;

  typedef struct packed {
    logic       accept;
    logic       mul_en;
    mul_phase_e phase;
    logic       src_rate;
    logic       commit;
    logic       finish;
  } mapu_cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic last;
    logic kill;
    logic out_free;
  } mapu_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mapu_if.sv
// Valid/ready channel interfaces for species requests and result requests.
// Depends on mapu_pkg.
`default_nettype none

interface mapu_species_if;
  import mapu_pkg::*;

  logic               valid;
  logic               ready;
  logic [ORDER_W-1:0] reactant_order;
  logic [MOLECULE_W-1:0] molecule_count;
  logic               last_species;

  modport source (output valid, output reactant_order, output molecule_count,
                  output last_species, input ready);
  modport sink   (input valid, input reactant_order, input molecule_count,
                  input last_species, output ready);
endinterface

interface mapu_result_if;
  import mapu_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] propensity;
  logic              saturated;

  modport source (output valid, output propensity, output saturated, input ready);
  modport sink   (input valid, input propensity, input saturated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/mapu_datapath.sv
// Datapath: configuration registers, running product, shared 32x32 multiplier
// with partial-product accumulation, and the output register. Uses mapu_pkg.
`default_nettype none

module mapu_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mapu_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mapu_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [mapu_pkg::ORDER_W-1:0]     reactant_order_i,
  input  logic [mapu_pkg::MOLECULE_W-1:0]  molecule_count_i,
  input  logic                             last_species_i,
  input  mapu_pkg::mapu_cmd_t              cmd_i,
  output mapu_pkg::mapu_status_t           status_o,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [mapu_pkg::DATA_W-1:0]      propensity_o,
  output logic                             saturated_o
);
  import mapu_pkg::*;

  logic [DATA_W-1:0]     rate_q;
  logic                  active_q;
  logic [DATA_W-1:0]     prod_q;
  logic                  short_q;
  logic                  povf_q;
  logic [ORDER_W-1:0]    rem_q;
  logic                  last_q;
  logic [COUNT_BITS-1:0] factor_q;
  logic [DATA_W-1:0]     mp_q;
  logic                  acc_en_q;
  mul_phase_e            acc_ph_q;
  logic [HALF_W-1:0]     lo_q;
  logic [MID_W-1:0]      mid_q;
  logic                  hovf_q;
  logic                  out_valid_q;
  logic [DATA_W-1:0]     prop_q;
  logic                  sat_q;

  logic [ORDER_W-1:0]    ord_clamp;
  logic [DATA_W-1:0]     cnt_ext;
  logic [COUNT_BITS-1:0] count;
  logic                  short_now;
  logic [DATA_W-1:0]     op_b;
  logic [HALF_W-1:0]     mul_a;
  logic [HALF_W-1:0]     mul_b;
  logic [DATA_W-1:0]     mul_res;
  logic [MID_W-1:0]      mid_fin;
  logic                  fin_ovf;
  logic [DATA_W-1:0]     fin_res;
  logic                  kill;

  assign ord_clamp = (reactant_order_i > MAX_ORDER) ? MAX_ORDER : reactant_order_i;
  assign cnt_ext   = {{(DATA_W-MOLECULE_W){1'b0}}, molecule_count_i};
  assign count     = cnt_ext[COUNT_BITS-1:0];
  assign short_now = (ord_clamp != '0) &&
                     ({{(COUNT_BITS-ORDER_W){1'b0}}, ord_clamp} > count);

  assign op_b = cmd_i.src_rate ? rate_q : {{(DATA_W-COUNT_BITS){1'b0}}, factor_q};

  always_comb begin
    mul_a = prod_q[HALF_W-1:0];
    mul_b = op_b[HALF_W-1:0];
    case (cmd_i.phase)
      PH_LL: begin
        mul_a = prod_q[HALF_W-1:0];
        mul_b = op_b[HALF_W-1:0];
      end
      PH_LH: begin
        mul_a = prod_q[HALF_W-1:0];
        mul_b = op_b[DATA_W-1:HALF_W];
      end
      PH_HL: begin
        mul_a = prod_q[DATA_W-1:HALF_W];
        mul_b = op_b[HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_res = DATA_W'(mul_a) * DATA_W'(mul_b);

  // The high-by-high term is never formed: it is nonzero exactly when both
  // high halves are, and that alone means overflow.
  assign mid_fin = mid_q + {2'b00, mp_q[HALF_W-1:0]};
  assign fin_ovf = hovf_q | (|mp_q[DATA_W-1:HALF_W]) | (|mid_fin[MID_W-1:HALF_W]);
  assign fin_res = fin_ovf ? '1 : {mid_fin[HALF_W-1:0], lo_q};

  assign kill = !active_q || short_q;

  assign status_o.rem_zero = (rem_q == '0);
  assign status_o.last     = last_q;
  assign status_o.kill     = kill;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= '0;
      active_q    <= 1'b1;
      prod_q      <= DATA_W'(1);
      short_q     <= 1'b0;
      povf_q      <= 1'b0;
      rem_q       <= '0;
      last_q      <= 1'b0;
      acc_en_q    <= 1'b0;
      acc_ph_q    <= PH_LL;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_RATE_CONSTANT:   rate_q   <= cfg_data_i;
          REG_REACTION_ACTIVE: active_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      acc_en_q <= cmd_i.mul_en;
      acc_ph_q <= cmd_i.phase;
      if (cmd_i.accept) begin
        rem_q  <= short_now ? '0 : ord_clamp;
        last_q <= last_species_i;
        if (short_now) begin
          short_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        prod_q <= fin_res;
        rem_q  <= rem_q - 1'b1;
        if (fin_ovf) begin
          povf_q <= 1'b1;
        end
      end
      if (cmd_i.finish) begin
        prod_q      <= DATA_W'(1);
        short_q     <= 1'b0;
        povf_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      factor_q <= count;
    end else if (cmd_i.commit) begin
      factor_q <= factor_q - 1'b1;
    end
    if (cmd_i.mul_en) begin
      mp_q <= mul_res;
    end
    // Partial products land in the cycle after they are formed; the last one
    // is folded in combinationally when the result is taken.
    if (acc_en_q) begin
      case (acc_ph_q)
        PH_LL: begin
          lo_q   <= mp_q[HALF_W-1:0];
          mid_q  <= {2'b00, mp_q[DATA_W-1:HALF_W]};
          hovf_q <= (|prod_q[DATA_W-1:HALF_W]) && (|op_b[DATA_W-1:HALF_W]);
        end
        PH_LH: begin
          mid_q  <= mid_q + {2'b00, mp_q[HALF_W-1:0]};
          hovf_q <= hovf_q | (|mp_q[DATA_W-1:HALF_W]);
        end
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      if (kill) begin
        prop_q <= '0;
        sat_q  <= 1'b0;
      end else begin
        prop_q <= (rate_q == '0) ? '0 : fin_res;
        sat_q  <= povf_q | fin_ovf;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign propensity_o = prop_q;
  assign saturated_o  = sat_q;

endmodule

`default_nettype wire

FILE: hw/rtl/mapu_ctrl.sv
// Controller: sequences one species request through its multiplications and
// the final rate scaling. Uses mapu_pkg; drives mapu_datapath.
`default_nettype none

module mapu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  mapu_pkg::mapu_status_t status_i,
  output mapu_pkg::mapu_cmd_t    cmd_o
);
  import mapu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_LL,
    S_LH,
    S_HL,
    S_FIN
  } state_e;

  state_e state_q;
  logic   final_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.phase    = PH_LL;
    cmd_o.src_rate = final_q;
    cmd_o.accept   = in_valid_i && in_ready_o;
    case (state_q)
      S_IDLE: ;
      S_CHECK: begin
        if (status_i.rem_zero && status_i.last && status_i.kill) begin
          cmd_o.finish = status_i.out_free;
        end
      end
      S_LL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.phase  = PH_LL;
      end
      S_LH: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.phase  = PH_LH;
      end
      S_HL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.phase  = PH_HL;
      end
      S_FIN: begin
        if (final_q) begin
          cmd_o.finish = status_i.out_free;
        end else begin
          cmd_o.commit = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      final_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (!status_i.rem_zero) begin
            final_q <= 1'b0;
            state_q <= S_LL;
          end else if (!status_i.last) begin
            state_q <= S_IDLE;
          end else if (status_i.kill) begin
            if (status_i.out_free) begin
              state_q <= S_IDLE;
            end
          end else begin
            final_q <= 1'b1;
            state_q <= S_LL;
          end
        end
        S_LL: state_q <= S_LH;
        S_LH: state_q <= S_HL;
        S_HL: state_q <= S_FIN;
        S_FIN: begin
          if (!final_q) begin
            state_q <= S_CHECK;
          end else if (status_i.out_free) begin
            final_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/mass_action_propensity_unit.sv
// Top level of the mass-action propensity unit: controller plus datapath.
// Depends on mapu_pkg, mapu_if, mapu_ctrl and mapu_datapath.
`default_nettype none

// Species requests arrive one per reaction reactant; each folds the falling
// factorial count*(count-1)*...*(count-order+1) into a running 64-bit product
// that clamps at all ones. All multiplications go through one shared 32x32
// multiplier, three partial products per 64-bit step, one step per factor
// (orders above four count as four; a species with fewer molecules than its
// order takes no step). On the request flagged as the last species the
// product is scaled by the Q32.32 rate constant, skipped when the reaction
// is inactive or a species was short. The result then sits in an output
// register, so the next species request is accepted while it waits. The user
// must write registers through cfg_we_i only while the unit is idle; the block
// does not enforce it. Index 0 is the rate constant, index 1 the active flag.
module mass_action_propensity_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mapu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mapu_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mapu_species_if.sink                    species_i,
  mapu_result_if.source                   result_o
);
  import mapu_pkg::*;

  mapu_cmd_t    cmd;
  mapu_status_t status;
  logic         in_ready;

  mapu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (species_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mapu_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .reactant_order_i (species_i.reactant_order),
    .molecule_count_i (species_i.molecule_count),
    .last_species_i   (species_i.last_species),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_ready_i      (result_o.ready),
    .out_valid_o      (result_o.valid),
    .propensity_o     (result_o.propensity),
    .saturated_o      (result_o.saturated)
  );

  assign species_i.ready = in_ready;

endmodule

`default_nettype wire

FILE: hw/rtl/mapu_checker.sv
// Port-level checker for the mass-action propensity unit and its bind.
// Depends on mapu_pkg and mass_action_propensity_unit.
`default_nettype none

module mapu_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [mapu_pkg::DATA_W-1:0] propensity_i,
  input logic                        saturated_i
);
  import mapu_pkg::*;

  // A held result request keeps its valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  // A held result request keeps its propensity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(propensity_i))
    else $error("propensity changed while stalled");

  // Every species passes through the check state before the next is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("species accepted on back-to-back cycles");

  // A clamped result is all ones, or zero for a zero rate constant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && saturated_i |-> (propensity_i == '1 || propensity_i == '0))
    else $error("saturated result is not clamped");

endmodule

bind mass_action_propensity_unit mapu_checker u_mapu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (species_i.valid),
  .in_ready_i   (species_i.ready),
  .out_valid_i  (result_o.valid),
  .out_ready_i  (result_o.ready),
  .propensity_i (result_o.propensity),
  .saturated_i  (result_o.saturated)
);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for mass_action_propensity_unit: directed and random
// species requests, an in-bench propensity predictor and random stalls on both sides.
// Depends on mapu_pkg, mapu_if and the unit's RTL.
`default_nettype none

module tb_top;
  import mapu_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned PHASE_ITEMS  = 180;
  localparam logic [DATA_W-1:0] RATE_ONE = 64'h0000_0001_0000_0000;

  typedef struct packed {
    logic [ORDER_W-1:0]    order;
    logic [MOLECULE_W-1:0] count;
    logic                  last;
  } species_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] propensity;
    logic              saturated;
  } propensity_res_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  mapu_species_if species_if ();
  mapu_result_if  result_if ();

  mass_action_propensity_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .species_i  (species_if),
    .result_o   (result_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  species_req_t    species_backlog[$];
  propensity_res_t expected_propensity_q[$];

  // Predictor copy of the configuration and the per-reaction accumulators.
  logic [DATA_W-1:0] rate_q;
  logic              active_q;
  logic [DATA_W-1:0] running_product;
  logic              species_short;
  logic              product_clamped;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned queued_cnt;
  int unsigned accepted_cnt;
  int unsigned results_checked;
  int unsigned error_cnt;
  int unsigned cycle_cnt;

  // Saturating 64x64 multiply: bit 64 flags the clamp.
  function automatic logic [DATA_W:0] clamp_mul(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [2*DATA_W-1:0] wide;
    wide = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
    if (wide[2*DATA_W-1:DATA_W] != '0) begin
      return {1'b1, {DATA_W{1'b1}}};
    end
    return {1'b0, wide[DATA_W-1:0]};
  endfunction

  // Folds one species into the running product; returns 1 when it ends the
  // reaction, with the expected result in res.
  function automatic logic fold_species(input species_req_t req,
                                        output propensity_res_t res);
    logic [ORDER_W-1:0] ord;
    logic [DATA_W-1:0]  cnt;
    logic [DATA_W:0]    m;
    ord = (req.order > MAX_ORDER) ? MAX_ORDER : req.order;
    cnt = DATA_W'(req.count[COUNT_BITS-1:0]);
    res = '0;
    if (ord != '0) begin
      if (DATA_W'(ord) > cnt) begin
        species_short = 1'b1;
      end else begin
        for (int k = 0; k < int'(ord); k++) begin
          m = clamp_mul(running_product, cnt - DATA_W'(k));
          running_product = m[DATA_W-1:0];
          if (m[DATA_W]) product_clamped = 1'b1;
        end
      end
    end
    if (!req.last) return 1'b0;
    if (active_q && !species_short) begin
      m = clamp_mul(running_product, rate_q);
      res.propensity = (rate_q == '0) ? '0 : m[DATA_W-1:0];
      res.saturated  = product_clamped | m[DATA_W];
    end
    running_product = DATA_W'(1);
    species_short   = 1'b0;
    product_clamped = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("tb_top: mismatch at cycle %0d: %s", cycle_cnt, what);
    error_cnt++;
  endtask

  // Species driver: a new request goes out only when the previous one is taken.
  always @(posedge clk_i) begin
    species_req_t    req;
    species_req_t    nxt;
    propensity_res_t res;
    if (!rst_ni) begin
      species_if.valid <= 1'b0;
    end else begin
      if (species_if.valid && species_if.ready) begin
        req.order = species_if.reactant_order;
        req.count = species_if.molecule_count;
        req.last  = species_if.last_species;
        accepted_cnt++;
        if (fold_species(req, res)) expected_propensity_q.push_back(res);
      end
      if (!species_if.valid || species_if.ready) begin
        if (species_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = species_backlog.pop_front();
          species_if.valid          <= 1'b1;
          species_if.reactant_order <= nxt.order;
          species_if.molecule_count <= nxt.count;
          species_if.last_species   <= nxt.last;
        end else begin
          species_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with a randomly stalling ready.
  always @(posedge clk_i) begin
    propensity_res_t exp_res;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        results_checked++;
        if (expected_propensity_q.size() == 0) begin
          report_mismatch("result request with no result expected");
        end else begin
          exp_res = expected_propensity_q.pop_front();
          if (result_if.propensity !== exp_res.propensity) begin
            report_mismatch($sformatf("propensity %h, expected %h",
                                      result_if.propensity, exp_res.propensity));
          end
          if (result_if.saturated !== exp_res.saturated) begin
            report_mismatch($sformatf("saturated %b, expected %b",
                                      result_if.saturated, exp_res.saturated));
          end
        end
      end
      result_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: timeout with %0d results outstanding", expected_propensity_q.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == REG_RATE_CONSTANT) rate_q = data;
    else active_q = data[0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_species(input int unsigned order, input logic [MOLECULE_W-1:0] count,
                              input logic last);
    species_req_t req;
    req.order = ORDER_W'(order);
    req.count = count;
    req.last  = last;
    species_backlog.push_back(req);
    queued_cnt++;
  endtask

  // Waits until every request is taken and every result has come back, then
  // leaves room for a species that produces no result to finish.
  task automatic drain_unit();
    while (accepted_cnt != queued_cnt || expected_propensity_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly small counts so that products stay in range; a few huge ones to clamp.
  function automatic logic [MOLECULE_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return MOLECULE_W'($urandom_range(0, 12));
    if (r < 75) return MOLECULE_W'($urandom_range(0, 300));
    if (r < 88) return MOLECULE_W'($urandom_range(0, 70000));
    if (r < 94) return $urandom;
    if (r < 97) return {MOLECULE_W{1'b1}};
    return MOLECULE_W'($urandom_range(0, 4));
  endfunction

  function automatic int unsigned pick_order();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 7);
  endfunction

  task automatic queue_random_phase(input int unsigned n_items);
    int unsigned added;
    int unsigned n_species;
    added = 0;
    while (added < n_items) begin
      if ($urandom_range(0, 99) < 10) begin
        // Loose species that may leave a reaction half built.
        push_species($urandom_range(0, 7), $urandom, 1'($urandom_range(0, 1)));
        added++;
      end else begin
        n_species = $urandom_range(1, 4);
        for (int s = 0; s < int'(n_species); s++) begin
          push_species(pick_order(), pick_count(), s == int'(n_species) - 1);
        end
        added += n_species;
      end
    end
    push_species(pick_order(), pick_count(), 1'b1);
  endtask

  initial begin
    species_if.valid          = 1'b0;
    species_if.reactant_order = '0;
    species_if.molecule_count = '0;
    species_if.last_species   = 1'b0;
    result_if.ready           = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_RATE_CONSTANT;
    cfg_data_i      = '0;
    rst_ni          = 1'b0;
    rate_q          = '0;
    active_q        = 1'b1;
    running_product = DATA_W'(1);
    species_short   = 1'b0;
    product_clamped = 1'b0;
    queued_cnt      = 0;
    accepted_cnt    = 0;
    results_checked = 0;
    error_cnt       = 0;
    cycle_cnt       = 0;
    send_idle_pct   = 16;
    recv_idle_pct   = 48;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Rate of 2^32: results are the factorial products shifted up by 32 bits.
    write_reg(REG_RATE_CONSTANT, RATE_ONE);
    write_reg(REG_REACTION_ACTIVE, CFG_DATA_W'(1));
    push_species(0, 0, 1'b1);
    push_species(1, 0, 1'b1);
    push_species(2, 1, 1'b1);
    push_species(4, 4, 1'b1);
    push_species(7, 5, 1'b1);
    push_species(5, 3, 1'b0);
    push_species(1, 7, 1'b1);
    push_species(3, 10, 1'b0);
    push_species(0, 99, 1'b0);
    push_species(2, 6, 1'b1);
    push_species(4, 32'hFFFF_FFFF, 1'b0);
    push_species(4, 32'hFFFF_FFFF, 1'b1);
    push_species(2, 32'hFFFF_FFFF, 1'b1);
    push_species(6, 32'hFFFF_FFFF, 1'b1);
    push_species(1, 32'h8000_0000, 1'b1);
    drain_unit();

    // Zero rate, with and without a clamped product.
    write_reg(REG_RATE_CONSTANT, '0);
    push_species(3, 50, 1'b1);
    push_species(4, 32'hFFFF_FFFF, 1'b1);
    drain_unit();

    // Largest rate: any product above one overflows the scaling.
    write_reg(REG_RATE_CONSTANT, {CFG_DATA_W{1'b1}});
    push_species(1, 1, 1'b1);
    push_species(1, 2, 1'b1);
    push_species(0, 0, 1'b1);
    drain_unit();

    write_reg(REG_REACTION_ACTIVE, '0);
    push_species(2, 5, 1'b1);
    push_species(4, 32'hFFFF_FFFF, 1'b1);
    drain_unit();

    for (int phase = 0; phase < 6; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 16;
        recv_idle_pct = 48;
      end else if (phase < 4) begin
        send_idle_pct = 48;
        recv_idle_pct = 16;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: write_reg(REG_RATE_CONSTANT, {24'b0, 8'($urandom), 32'($urandom)});
        1: write_reg(REG_RATE_CONSTANT, CFG_DATA_W'(1));
        2: write_reg(REG_RATE_CONSTANT, {32'($urandom), 32'($urandom)});
        3: write_reg(REG_RATE_CONSTANT, {32'($urandom), 32'($urandom)});
        4: write_reg(REG_RATE_CONSTANT, RATE_ONE);
        default: write_reg(REG_RATE_CONSTANT, {16'b0, 16'($urandom), 32'($urandom)});
      endcase
      write_reg(REG_REACTION_ACTIVE, CFG_DATA_W'(phase != 3));
      queue_random_phase(PHASE_ITEMS);
      drain_unit();
    end

    $display("tb_top: %0d species requests taken, %0d propensities checked, %0d mismatches",
             accepted_cnt, results_checked, error_cnt);
    $display("tb_top: covered four directed groups and six random phases under three stall mixes");
    if (error_cnt == 0 && expected_propensity_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
